// ===== rtl/gsp_pkg.sv =====
// Shared types and constants for the grid shortest-path block.
`timescale 1ns / 1ps

package gsp_pkg;

	// Default grid size.
	localparam int GRID_WIDTH_DEF  = 16;
	localparam int GRID_HEIGHT_DEF = 16;

	// Field widths.
	localparam int COORD_W = 4;
	localparam int DIST_W  = 16;
	localparam int PAR_W   = 8;

	// Distance of a node that has not been reached.
	localparam logic [DIST_W-1:0] UNREACHED = 16'hFFFF;

	// Item and reply kinds.
	typedef enum logic {
		KIND_RUN   = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

endpackage

// ===== rtl/gsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/grid_shortest_path_relaxation.sv =====
// Unit-weight Bellman-Ford shortest paths on a four-connected grid, with a shared relax unit.
// A run transaction first sweeps the distance, parent and parent-valid memories, one node per
// cycle (the same sweep runs once after reset, with in_ready low), then writes the source and
// makes relaxation passes until a pass changes nothing or V-1 passes are done; a source outside
// the grid skips the passes and is acknowledged after the sweep. Each pass visits every node,
// x outer and y inner; a reached node tries edges left, right, up, down, and every existing
// edge is read, compared and, if improved, written through the single port pair of the distance
// memory. A query transaction reads the node's memories and passes its result through the reply
// state to the result register. One transaction is worked on at a time; the result register
// lets the next transaction be accepted while a result waits.
`timescale 1ns / 1ps

module grid_shortest_path_relaxation
	import gsp_pkg::*;
#(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [COORD_W-1:0] x,
	input  logic [COORD_W-1:0] y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               reply_kind,
	output logic [DIST_W-1:0]  distance,
	output logic               parent_valid,
	output logic [PAR_W-1:0]   parent_index
);

	localparam int NODE_COUNT = GRID_WIDTH * GRID_HEIGHT;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int XW         = $clog2(GRID_WIDTH);
	localparam int YW         = $clog2(GRID_HEIGHT);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SRC,
		ST_NODE_RD,
		ST_NODE_GET,
		ST_EDGE,
		ST_RELAX,
		ST_QUERY_RD,
		ST_QUERY_GET,
		ST_REPLY
	} state_t;

	typedef enum logic [1:0] {
		EDGE_LEFT,
		EDGE_RIGHT,
		EDGE_UP,
		EDGE_DOWN
	} edge_t;

	state_t              state_q;
	logic [NODE_W-1:0]   clr_q;
	logic [NODE_W-1:0]   pass_q;
	logic [XW-1:0]       gx_q;
	logic [YW-1:0]       gy_q;
	edge_t               e_q;
	logic [NODE_W-1:0]   v_q;
	logic [DIST_W-1:0]   du_q;
	logic                changed_q;
	logic                run_q;
	logic                ok_q;
	logic [NODE_W-1:0]   idx_q;
	kind_t               res_kind_q;
	logic [DIST_W-1:0]   res_dist_q;
	logic                res_pv_q;
	logic [PAR_W-1:0]    res_par_q;
	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_pv_q;
	logic [PAR_W-1:0]    out_par_q;

	logic                in_grid;
	logic [NODE_W-1:0]   in_idx;
	logic [NODE_W-1:0]   u_idx;
	logic [NODE_W-1:0]   v_nb;
	logic                edge_present;
	logic                improve;
	logic                changed_now;
	logic                node_done;
	logic                pass_end;
	logic                last_pass;
	logic                out_load;

	logic                ram_we;
	logic [NODE_W-1:0]   ram_waddr;
	logic [NODE_W-1:0]   ram_raddr;
	logic [DIST_W-1:0]   wd_dist;
	logic [PAR_W-1:0]    wd_par;
	logic                wd_pv;
	logic [DIST_W-1:0]   rd_dist;
	logic [PAR_W-1:0]    rd_par;
	logic                rd_pv;

	// Node index of the incoming coordinates and of the node being visited.
	assign in_grid = (32'(x) < GRID_WIDTH) && (32'(y) < GRID_HEIGHT);
	assign in_idx  = NODE_W'(32'(y) * GRID_WIDTH + 32'(x));
	assign u_idx   = NODE_W'(32'(gy_q) * GRID_WIDTH + 32'(gx_q));

	// Neighbor on the current edge and whether that edge exists.
	always_comb begin
		edge_present = 1'b0;
		v_nb         = u_idx;
		case (e_q)
			EDGE_LEFT: begin
				edge_present = (gx_q != '0);
				v_nb         = u_idx - NODE_W'(1);
			end
			EDGE_RIGHT: begin
				edge_present = (gx_q != XW'(GRID_WIDTH - 1));
				v_nb         = u_idx + NODE_W'(1);
			end
			EDGE_UP: begin
				edge_present = (gy_q != '0);
				v_nb         = u_idx - NODE_W'(GRID_WIDTH);
			end
			EDGE_DOWN: begin
				edge_present = (gy_q != YW'(GRID_HEIGHT - 1));
				v_nb         = u_idx + NODE_W'(GRID_WIDTH);
			end
			default: begin
				edge_present = 1'b0;
				v_nb         = u_idx;
			end
		endcase
	end

	// Shared relax unit: one increment and one compare against the neighbor's distance.
	assign improve     = (state_q == ST_RELAX) && ((du_q + DIST_W'(1)) < rd_dist);
	assign changed_now = changed_q | improve;

	// The visit of the current node ends this cycle.
	assign node_done = ((state_q == ST_NODE_GET) && (rd_dist == UNREACHED)) ||
		((state_q == ST_EDGE) && !edge_present && (e_q == EDGE_DOWN)) ||
		((state_q == ST_RELAX) && (e_q == EDGE_DOWN));
	assign pass_end  = (gx_q == XW'(GRID_WIDTH - 1)) && (gy_q == YW'(GRID_HEIGHT - 1));
	assign last_pass = (pass_q == NODE_W'(NODE_COUNT - 1));

	// The finished transaction moves into the result register when that register is free.
	assign out_load = (state_q == ST_REPLY) && (!out_valid_q || out_ready);

	// Memory port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		wd_dist   = UNREACHED;
		wd_par    = '0;
		wd_pv     = 1'b0;
		ram_raddr = u_idx;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_SRC: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				wd_dist   = '0;
			end
			ST_EDGE: begin
				ram_raddr = v_nb;
			end
			ST_RELAX: begin
				ram_we    = improve;
				ram_waddr = v_q;
				wd_dist   = du_q + DIST_W'(1);
				wd_par    = PAR_W'(u_idx);
				wd_pv     = 1'b1;
			end
			ST_QUERY_RD: begin
				ram_raddr = idx_q;
			end
			default: begin
				ram_raddr = u_idx;
			end
		endcase
	end

	gsp_ram #(.WIDTH(DIST_W), .DEPTH(NODE_COUNT)) u_dist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wd_dist),
		.raddr (ram_raddr),
		.rdata (rd_dist)
	);

	gsp_ram #(.WIDTH(PAR_W), .DEPTH(NODE_COUNT)) u_par_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wd_par),
		.raddr (ram_raddr),
		.rdata (rd_par)
	);

	gsp_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_pv_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wd_pv),
		.raddr (ram_raddr),
		.rdata (rd_pv)
	);

	// Sequencer, working registers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pass_q      <= '0;
			gx_q        <= '0;
			gy_q        <= '0;
			e_q         <= EDGE_LEFT;
			v_q         <= '0;
			du_q        <= '0;
			changed_q   <= 1'b0;
			run_q       <= 1'b0;
			ok_q        <= 1'b0;
			idx_q       <= '0;
			res_kind_q  <= KIND_RUN;
			res_dist_q  <= '0;
			res_pv_q    <= 1'b0;
			res_par_q   <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_RUN;
			out_dist_q  <= '0;
			out_pv_q    <= 1'b0;
			out_par_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Step to the next node, and at the end of a pass decide whether to go on.
			if (node_done) begin
				if (pass_end) begin
					gx_q <= '0;
					gy_q <= '0;
					if (!changed_now || last_pass) begin
						res_kind_q <= KIND_RUN;
						res_dist_q <= '0;
						res_pv_q   <= 1'b0;
						res_par_q  <= '0;
						state_q    <= ST_REPLY;
					end else begin
						pass_q    <= pass_q + NODE_W'(1);
						changed_q <= 1'b0;
						state_q   <= ST_NODE_RD;
					end
				end else begin
					changed_q <= changed_now;
					state_q   <= ST_NODE_RD;
					if (gy_q == YW'(GRID_HEIGHT - 1)) begin
						gy_q <= '0;
						gx_q <= gx_q + XW'(1);
					end else begin
						gy_q <= gy_q + YW'(1);
					end
				end
			end else begin
				case (state_q)
					ST_CLEAR: begin
						if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
							clr_q <= '0;
							if (!run_q) begin
								state_q <= ST_IDLE;
							end else if (ok_q) begin
								state_q <= ST_SRC;
							end else begin
								res_kind_q <= KIND_RUN;
								res_dist_q <= '0;
								res_pv_q   <= 1'b0;
								res_par_q  <= '0;
								state_q    <= ST_REPLY;
							end
						end else begin
							clr_q <= clr_q + NODE_W'(1);
						end
					end
					ST_IDLE: begin
						if (in_valid) begin
							idx_q <= in_idx;
							ok_q  <= in_grid;
							if (kind == KIND_RUN) begin
								run_q   <= 1'b1;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end else begin
								state_q <= ST_QUERY_RD;
							end
						end
					end
					ST_SRC: begin
						pass_q    <= NODE_W'(1);
						gx_q      <= '0;
						gy_q      <= '0;
						changed_q <= 1'b0;
						state_q   <= ST_NODE_RD;
					end
					ST_NODE_RD: begin
						state_q <= ST_NODE_GET;
					end
					ST_NODE_GET: begin
						du_q    <= rd_dist;
						e_q     <= EDGE_LEFT;
						state_q <= ST_EDGE;
					end
					ST_EDGE: begin
						v_q <= v_nb;
						if (edge_present) begin
							state_q <= ST_RELAX;
						end else begin
							e_q <= edge_t'(e_q + 2'd1);
						end
					end
					ST_RELAX: begin
						changed_q <= changed_now;
						e_q       <= edge_t'(e_q + 2'd1);
						state_q   <= ST_EDGE;
					end
					ST_QUERY_RD: begin
						state_q <= ST_QUERY_GET;
					end
					ST_QUERY_GET: begin
						res_kind_q <= KIND_QUERY;
						if (ok_q) begin
							res_dist_q <= rd_dist;
							res_pv_q   <= rd_pv;
							res_par_q  <= rd_par;
						end else begin
							res_dist_q <= UNREACHED;
							res_pv_q   <= 1'b0;
							res_par_q  <= '0;
						end
						state_q <= ST_REPLY;
					end
					ST_REPLY: begin
						if (out_load) begin
							out_kind_q <= res_kind_q;
							out_dist_q <= res_dist_q;
							out_pv_q   <= res_pv_q;
							out_par_q  <= res_par_q;
							state_q    <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign reply_kind   = out_kind_q;
	assign distance     = out_dist_q;
	assign parent_valid = out_pv_q;
	assign parent_index = out_par_q;

endmodule

// ===== rtl/gsp_checker.sv =====
// Port-level assertions for the grid shortest-path block, bound to its top level.
`timescale 1ns / 1ps

module gsp_checker
	import gsp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               reply_kind,
	input logic [DIST_W-1:0]  distance,
	input logic               parent_valid,
	input logic [PAR_W-1:0]   parent_index
);

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({reply_kind, distance, parent_valid, parent_index}))
		else $error("result changed while stalled");

	// Only one transaction is worked on at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

	// A run acknowledge carries zero fields.
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reply_kind == KIND_RUN) |->
		(distance == '0) && !parent_valid && (parent_index == '0))
		else $error("run acknowledge with nonzero fields");

	// A node with a recorded parent is reached and is not the source.
	a_parent_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parent_valid |-> (distance != '0) && (distance != UNREACHED))
		else $error("parent recorded with impossible distance");

	// Without a recorded parent the parent index reads as zero.
	a_no_parent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parent_valid |-> (parent_index == '0))
		else $error("parent index without parent");

endmodule

bind grid_shortest_path_relaxation gsp_checker u_gsp_checker (.*);
